[hdl/assert_macros.svh]
// Shared assertion macros for the segment table checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sst_pkg.sv]
package sst_pkg;

    localparam int POS_W   = 12;
    localparam int ID_W    = 6;
    localparam int SIZE_W  = 13;
    localparam int TOTAL_W = 7;

    // Size list depth; subtour ids and the total are sized for it.
    localparam int MAX_SUBTOURS = 64;

    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_ADD_SEG,
        OP_ADD_SIZE,
        OP_FIND_MIN,
        OP_FIND_POS,
        OP_START_POS,
        OP_MERGE,
        OP_COUNT
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NOT_FOUND,
        ST_FULL,
        ST_BAD_ID
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_MRG_RDA,
        S_MRG_RDB,
        S_MRG_SUM,
        S_MRG_RDL,
        S_MRG_MOVE,
        S_RELABEL1,
        S_RELABEL2,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] stop;
        logic [ID_W-1:0]  owner;
    } seg_entry_t;

endpackage

[hdl/sst_cmd_if.sv]
interface sst_cmd_if import sst_pkg::*;;
    logic                valid;
    logic                ready;
    op_t                 op;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    seg_start;
    logic [POS_W-1:0]    seg_stop;
    logic [ID_W-1:0]     subtour_a;
    logic [ID_W-1:0]     subtour_b;
    logic [SIZE_W-1:0]   size_value;

    modport source (output valid, op, position, seg_start, seg_stop, subtour_a,
                    subtour_b, size_value, input ready);
    modport sink   (input valid, op, position, seg_start, seg_stop, subtour_a,
                    subtour_b, size_value, output ready);
endinterface

[hdl/sst_res_if.sv]
interface sst_res_if import sst_pkg::*;;
    logic                valid;
    logic                ready;
    status_t             status;
    logic [ID_W-1:0]     found_id;
    logic [SIZE_W-1:0]   found_value;
    logic [TOTAL_W-1:0]  subtour_total;

    modport source (output valid, status, found_id, found_value, subtour_total,
                    input ready);
    modport sink   (input valid, status, found_id, found_value, subtour_total,
                    output ready);
endinterface

[hdl/subtour_segment_table.sv]
// Clear, add, count and a rejected merge pass through EXEC and FINISH to the output register.
// Find min / find containing / start pos pass through EXEC, SCAN (one entry per cycle) and FINISH.
// Merge: RDA, RDB, SUM, RDL, MOVE, then one or two relabel passes over the segment table, then FINISH.
// One command at a time; cmd.ready rises in the same cycle as result valid.
// cmd.ready is high only while the sequencer idles.
// Reset (rst_n, async, active low) empties both tables; entry contents are not cleared.
module subtour_segment_table import sst_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    sst_cmd_if.sink   cmd,
    sst_res_if.source res
);

    // Address and count widths follow the table depths.
    localparam int SEG_AW = $clog2(MAX_SEGMENTS);
    localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
    localparam int SZ_AW  = $clog2(MAX_SUBTOURS);
    localparam int SZ_CW  = $clog2(MAX_SUBTOURS + 1);
    localparam int IDX_W  = (SEG_CW > SZ_CW) ? SEG_CW : SZ_CW;

    // Sequencer
    state_t state_reg, state_next;

    // Latched command
    op_t               op_reg, op_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  sstart_reg, sstart_next;
    logic [POS_W-1:0]  sstop_reg, sstop_next;
    logic [ID_W-1:0]   a_reg, a_next;
    logic [ID_W-1:0]   b_reg, b_next;
    logic [SIZE_W-1:0] sval_reg, sval_next;

    // Table fill levels
    logic [SEG_CW-1:0] seg_total_reg, seg_total_next;
    logic [SZ_CW-1:0]  sz_total_reg, sz_total_next;

    // Scan pipeline: address issue, then evaluation of the registered read in the next cycle
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]  pipe_idx_reg, pipe_idx_next;

    // Result being built
    logic              found_reg, found_next;
    status_t           rstat_reg, rstat_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    logic [SIZE_W-1:0] rval_reg, rval_next;

    // Merge scratch: size of the target, relabel mapping
    logic [SIZE_W-1:0] hold_reg, hold_next;
    logic [ID_W-1:0]   rl_from_reg, rl_from_next;
    logic [ID_W-1:0]   rl_to_reg, rl_to_next;

    // Output register
    logic               out_vld_reg, out_vld_next;
    status_t            out_stat_reg, out_stat_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic [SIZE_W-1:0]  out_val_reg, out_val_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;

    // Memories
    seg_entry_t        seg_mem [MAX_SEGMENTS];
    seg_entry_t        seg_rd_reg;
    logic              seg_we;
    logic [SEG_AW-1:0] seg_waddr;
    seg_entry_t        seg_wdata;
    logic [SEG_AW-1:0] seg_raddr;

    logic [SIZE_W-1:0] sz_mem [MAX_SUBTOURS];
    logic [SIZE_W-1:0] sz_rd_reg;
    logic              sz_we;
    logic [SZ_AW-1:0]  sz_waddr;
    logic [SIZE_W-1:0] sz_wdata;
    logic [SZ_AW-1:0]  sz_raddr;

    // Shared decode
    logic              accept;
    logic              out_load;
    logic [SZ_CW-1:0]  last_id;
    logic              merge_bad;
    logic              b_lt_last;
    logic [IDX_W-1:0]  scan_limit;
    logic              scan_issue;
    logic              scan_done;
    logic [SIZE_W:0]   sum_full;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_load  = (state_reg == S_FINISH) && (!out_vld_reg || res.ready);

    assign last_id   = sz_total_reg - SZ_CW'(1);
    assign merge_bad = (32'(a_reg) >= 32'(sz_total_reg)) ||
                       (32'(b_reg) >= 32'(sz_total_reg)) || (a_reg == b_reg);
    assign b_lt_last = (32'(b_reg) < 32'(last_id));

    // Find min walks the size list; everything else walks the segment table.
    assign scan_limit = (state_reg == S_SCAN && op_reg == OP_FIND_MIN) ?
                        IDX_W'(sz_total_reg) : IDX_W'(seg_total_reg);
    assign scan_issue = (idx_reg < scan_limit);
    assign scan_done  = !scan_issue && !pipe_vld_reg;

    // Saturating size sum for merge
    assign sum_full = {1'b0, hold_reg} + {1'b0, sz_rd_reg};

    assign res.valid         = out_vld_reg;
    assign res.status        = out_stat_reg;
    assign res.found_id      = out_id_reg;
    assign res.found_value   = out_val_reg;
    assign res.subtour_total = out_total_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg) inside
                    OP_FIND_MIN, OP_FIND_POS, OP_START_POS: state_next = S_SCAN;
                    OP_MERGE: state_next = merge_bad ? S_FINISH : S_MRG_RDA;
                    default:  state_next = S_FINISH;
                endcase
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_MRG_RDA:  state_next = S_MRG_RDB;
            S_MRG_RDB:  state_next = S_MRG_SUM;
            S_MRG_SUM:  state_next = S_MRG_RDL;
            S_MRG_RDL:  state_next = S_MRG_MOVE;
            S_MRG_MOVE: state_next = S_RELABEL1;
            S_RELABEL1:
            begin
                if (scan_done)
                begin
                    state_next = b_lt_last ? S_RELABEL2 : S_FINISH;
                end
            end
            S_RELABEL2:
            begin
                if (scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        op_next        = op_reg;
        pos_next       = pos_reg;
        sstart_next    = sstart_reg;
        sstop_next     = sstop_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        sval_next      = sval_reg;
        seg_total_next = seg_total_reg;
        sz_total_next  = sz_total_reg;
        idx_next       = idx_reg;
        pipe_vld_next  = 1'b0;
        pipe_idx_next  = idx_reg;
        found_next     = found_reg;
        rstat_next     = rstat_reg;
        rid_next       = rid_reg;
        rval_next      = rval_reg;
        hold_next      = hold_reg;
        rl_from_next   = rl_from_reg;
        rl_to_next     = rl_to_reg;

        seg_we    = 1'b0;
        seg_waddr = pipe_idx_reg[SEG_AW-1:0];
        seg_wdata = seg_rd_reg;
        seg_raddr = idx_reg[SEG_AW-1:0];
        sz_we     = 1'b0;
        sz_waddr  = SZ_AW'(a_reg);
        sz_wdata  = sval_reg;
        sz_raddr  = idx_reg[SZ_AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = cmd.op;
                    pos_next    = cmd.position;
                    sstart_next = cmd.seg_start;
                    sstop_next  = cmd.seg_stop;
                    a_next      = cmd.subtour_a;
                    b_next      = cmd.subtour_b;
                    sval_next   = cmd.size_value;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    rstat_next  = ST_OK;
                    rid_next    = '0;
                    rval_next   = '0;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_CLEAR:
                    begin
                        seg_total_next = '0;
                        sz_total_next  = '0;
                    end
                    OP_ADD_SEG:
                    begin
                        if (seg_total_reg >= SEG_CW'(MAX_SEGMENTS))
                        begin
                            rstat_next = ST_FULL;
                        end
                        else
                        begin
                            seg_we          = 1'b1;
                            seg_waddr       = seg_total_reg[SEG_AW-1:0];
                            seg_wdata.start = sstart_reg;
                            seg_wdata.stop  = sstop_reg;
                            seg_wdata.owner = a_reg;
                            seg_total_next  = seg_total_reg + SEG_CW'(1);
                        end
                    end
                    OP_ADD_SIZE:
                    begin
                        if (sz_total_reg >= SZ_CW'(MAX_SUBTOURS))
                        begin
                            rstat_next = ST_FULL;
                        end
                        else
                        begin
                            sz_we         = 1'b1;
                            sz_waddr      = sz_total_reg[SZ_AW-1:0];
                            sz_wdata      = sval_reg;
                            sz_total_next = sz_total_reg + SZ_CW'(1);
                        end
                    end
                    OP_MERGE:
                    begin
                        if (merge_bad)
                        begin
                            rstat_next = ST_BAD_ID;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                if (scan_issue)
                begin
                    idx_next      = idx_reg + IDX_W'(1);
                    pipe_vld_next = 1'b1;
                end
                if (pipe_vld_reg)
                begin
                    case (op_reg)
                        OP_FIND_MIN:
                        begin
                            // strict compare keeps the lowest index on ties
                            if (!found_reg || sz_rd_reg < rval_reg)
                            begin
                                found_next = 1'b1;
                                rval_next  = sz_rd_reg;
                                rid_next   = ID_W'(pipe_idx_reg);
                            end
                        end
                        OP_FIND_POS:
                        begin
                            if (!found_reg && seg_rd_reg.start <= pos_reg &&
                                pos_reg <= seg_rd_reg.stop)
                            begin
                                found_next = 1'b1;
                                rid_next   = seg_rd_reg.owner;
                            end
                        end
                        OP_START_POS:
                        begin
                            if (!found_reg && seg_rd_reg.owner == a_reg)
                            begin
                                found_next = 1'b1;
                                rval_next  = {1'b0, seg_rd_reg.start};
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (scan_done)
                begin
                    rstat_next = found_reg ? ST_OK : ST_NOT_FOUND;
                end
            end
            S_MRG_RDA:
            begin
                sz_raddr = SZ_AW'(a_reg);
            end
            S_MRG_RDB:
            begin
                sz_raddr  = SZ_AW'(b_reg);
                hold_next = sz_rd_reg;
            end
            S_MRG_SUM:
            begin
                sz_we    = 1'b1;
                sz_waddr = SZ_AW'(a_reg);
                sz_wdata = sum_full[SIZE_W] ? SIZE_SAT : sum_full[SIZE_W-1:0];
            end
            S_MRG_RDL:
            begin
                // read after the sum write, so a target in the last slot moves its new size
                sz_raddr = last_id[SZ_AW-1:0];
            end
            S_MRG_MOVE:
            begin
                if (b_lt_last)
                begin
                    sz_we    = 1'b1;
                    sz_waddr = SZ_AW'(b_reg);
                    sz_wdata = sz_rd_reg;
                end
                rl_from_next = b_reg;
                rl_to_next   = a_reg;
                idx_next     = '0;
            end
            S_RELABEL1, S_RELABEL2:
            begin
                if (scan_issue)
                begin
                    idx_next      = idx_reg + IDX_W'(1);
                    pipe_vld_next = 1'b1;
                end
                if (pipe_vld_reg && seg_rd_reg.owner == rl_from_reg)
                begin
                    seg_we          = 1'b1;
                    seg_waddr       = pipe_idx_reg[SEG_AW-1:0];
                    seg_wdata       = seg_rd_reg;
                    seg_wdata.owner = rl_to_reg;
                end
                if (scan_done && state_reg == S_RELABEL1)
                begin
                    // second pass renumbers the last subtour into the freed slot
                    idx_next      = '0;
                    rl_from_next  = ID_W'(last_id);
                    rl_to_next    = b_reg;
                    sz_total_next = last_id;
                end
            end
            S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register: holds a result while the sink stalls
    always_comb
    begin
        out_vld_next   = out_vld_reg;
        out_stat_next  = out_stat_reg;
        out_id_next    = out_id_reg;
        out_val_next   = out_val_reg;
        out_total_next = out_total_reg;
        if (out_load)
        begin
            out_vld_next   = 1'b1;
            out_stat_next  = rstat_reg;
            out_id_next    = rid_reg;
            out_val_next   = rval_reg;
            out_total_next = TOTAL_W'(sz_total_reg);
        end
        else if (res.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_total_reg <= '0;
            sz_total_reg  <= '0;
            pipe_vld_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_total_reg <= seg_total_next;
            sz_total_reg  <= sz_total_next;
            pipe_vld_reg  <= pipe_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        sstart_reg    <= sstart_next;
        sstop_reg     <= sstop_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        sval_reg      <= sval_next;
        idx_reg       <= idx_next;
        pipe_idx_reg  <= pipe_idx_next;
        found_reg     <= found_next;
        rstat_reg     <= rstat_next;
        rid_reg       <= rid_next;
        rval_reg      <= rval_next;
        hold_reg      <= hold_next;
        rl_from_reg   <= rl_from_next;
        rl_to_reg     <= rl_to_next;
        out_stat_reg  <= out_stat_next;
        out_id_reg    <= out_id_next;
        out_val_reg   <= out_val_next;
        out_total_reg <= out_total_next;
    end

    // Segment table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_mem[seg_waddr] <= seg_wdata;
        end
        seg_rd_reg <= seg_mem[seg_raddr];
    end

    // Size list: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (sz_we)
        begin
            sz_mem[sz_waddr] <= sz_wdata;
        end
        sz_rd_reg <= sz_mem[sz_raddr];
    end

endmodule

[hdl/sst_checker.sv]
`include "assert_macros.svh"

module sst_checker import sst_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [1:0]         res_status,
    input logic [ID_W-1:0]    res_found_id,
    input logic [SIZE_W-1:0]  res_found_value,
    input logic [TOTAL_W-1:0] res_subtour_total
);

    logic       cmd_xfer;
    logic       res_xfer;
    logic [1:0] pend_reg, pend_next;

    assign cmd_xfer = cmd_valid && cmd_ready;
    assign res_xfer = res_valid && res_ready;

    // commands transferred whose result has not been transferred yet
    always_comb
    begin
        pend_next = pend_reg;
        if (cmd_xfer && !res_xfer)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!cmd_xfer && res_xfer)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `SST_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(res_status) && $stable(res_found_id) &&
        $stable(res_found_value) && $stable(res_subtour_total),
        "stalled result changed")
    `SST_ASSERT_NEXT(a_one_cmd, clk, rst_n, cmd_xfer, !cmd_ready,
        "command taken while previous one in work")
    `SST_ASSERT_SAME(a_no_extra, clk, rst_n, res_valid, pend_reg != 2'd0,
        "result without a pending command")
    `SST_ASSERT_SAME(a_depth, clk, rst_n, cmd_xfer, pend_reg <= 2'd1,
        "more than one result outstanding at command transfer")

endmodule

bind subtour_segment_table sst_checker u_sst_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_status        (res.status),
    .res_found_id      (res.found_id),
    .res_found_value   (res.found_value),
    .res_subtour_total (res.subtour_total)
);
